>>> src/pbc_pkg.sv
// Package for the pixel brightness curve block.
// Shared widths, pipeline depths, derived-configuration struct and level table builder.
// No dependencies.
package pbc_pkg;

  localparam int LEVELS_DEF = 256;
  localparam int MW         = 12;
  localparam int SQ_STAGES  = 32;
  localparam int DIV_STAGES = 8;
  localparam int LAT        = 3 + SQ_STAGES + 3 + DIV_STAGES + 1;
  localparam int CFG_SETTLE = 2;
  localparam logic signed [15:0] IDENT_LIM = 16'sd16;

  typedef struct packed {
    logic signed [15:0] a;
    logic signed [28:0] d1;
    logic [55:0]        d1sq;
    logic [30:0]        den;
    logic               neg;
    logic               ident;
  } pbc_cfg_t;

  typedef logic [MW-1:0] ttab_t [256];

  function automatic ttab_t build_ttab(int m);
    ttab_t r;
    for (int i = 0; i < 256; i++) begin
      r[i] = MW'((i * m * 2 + 255) / 510);
    end
    return r;
  endfunction

endpackage

>>> src/pixel_brightness_curve.sv
// One pixel per cycle sustained, except while the output stalls or a config settles.
// The depth is set by the 32-stage square root and the 8-stage divider in each color lane.
// The whole pipeline advances whenever the output register is empty or taken.
// After a configuration write, derived constants settle and no input is taken meanwhile.
// Synchronous reset clears the intensity register (identity curve) and all valid bits.
module pixel_brightness_curve #(
  parameter int LEVELS = pbc_pkg::LEVELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // red_in, green_in, blue_in, alpha_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // red_out, green_out, blue_out, alpha_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // intensity
);
  import pbc_pkg::*;

  pbc_cfg_t       cfg;
  logic           busy;
  logic           ce;
  logic [LAT-1:0] vld;
  logic [7:0]     alpha_q [LAT];

  pbc_cfg #(.LEVELS(LEVELS)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .busy      (busy)
  );

  assign ce       = !vld[LAT-1] || m_tready;
  assign s_tready = ce && !busy;
  assign m_tvalid = vld[LAT-1];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    pbc_lane #(.LEVELS(LEVELS)) u_lane (
      .clk   (clk),
      .ce    (ce),
      .cfg   (cfg),
      .c_in  (s_tdata[8*i +: 8]),
      .c_out (m_tdata[8*i +: 8])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LAT-2:0], s_tvalid && s_tready};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      alpha_q[0] <= s_tdata[31:24];
      for (int i = 1; i < LAT; i++) begin
        alpha_q[i] <= alpha_q[i-1];
      end
    end
  end

  assign m_tdata[31:24] = alpha_q[LAT-1];

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst) busy |-> !s_tready)
    else $error("input taken while config settles");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst) !ce |=> $stable(vld))
    else $error("valid bits moved during stall");
  a_reset_clear: assert property (@(posedge clk) rst |=> vld == '0)
    else $error("valid bits not cleared by reset");
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst) cfg_valid |=> busy)
    else $error("config write did not start settle window");

endmodule

>>> src/pbc_cfg.sv
// Intensity register and the per-configuration constants derived from it.
// Depends on pbc_pkg.
module pbc_cfg #(
  parameter int LEVELS = pbc_pkg::LEVELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data,
  output pbc_pkg::pbc_cfg_t cfg,
  output logic              busy
);
  import pbc_pkg::*;

  localparam logic [MW-1:0] M = MW'(LEVELS - 1);

  logic signed [15:0] a;
  logic signed [28:0] d1;
  logic [26:0]        am;
  logic [55:0]        d1sq;
  logic [1:0]         cnt;
  logic signed [16:0] amq;
  logic [16:0]        aabs;
  logic [27:0]        d1abs;
  logic signed [29:0] d1_full;

  assign cfg_ready = 1'b1;
  assign amq  = $signed({a[15], a}) - 17'sd16384;
  assign aabs = a[15] ? 17'(-$signed({a[15], a})) : {1'b0, a};
  assign d1_full = amq * $signed({1'b0, M});
  assign d1abs = d1[28] ? 28'(-d1) : d1[27:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      a   <= '0;
      cnt <= '0;
    end else begin
      if (cfg_valid) begin
        a   <= $signed(cfg_data);
        cnt <= 2'(CFG_SETTLE);
      end else if (cnt != '0) begin
        cnt <= cnt - 2'd1;
      end
    end
    d1   <= d1_full[28:0];
    am   <= 27'(aabs) * 27'(M);
    d1sq <= d1abs * d1abs;
  end

  assign busy      = (cnt != '0);
  assign cfg.a     = a;
  assign cfg.d1    = d1;
  assign cfg.d1sq  = d1sq;
  assign cfg.den   = {1'b0, am, 3'b000};
  assign cfg.neg   = a[15];
  assign cfg.ident = (a >= -IDENT_LIM) && (a <= IDENT_LIM);

endmodule

>>> src/pbc_sqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband data.
// Depends on pbc_pkg.
module pbc_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              ce,
  input  logic [63:0]       x,
  input  logic [SIDE_W-1:0] side_in,
  output logic [31:0]       root,
  output logic [SIDE_W-1:0] side_out
);
  import pbc_pkg::*;

  logic [34:0]       rem_q  [SQ_STAGES];
  logic [31:0]       root_q [SQ_STAGES];
  logic [63:0]       x_q    [SQ_STAGES];
  logic [SIDE_W-1:0] sd_q   [SQ_STAGES];

  logic [34:0]       rem_p  [SQ_STAGES];
  logic [31:0]       root_p [SQ_STAGES];
  logic [63:0]       x_p    [SQ_STAGES];
  logic [SIDE_W-1:0] sd_p   [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    logic [34:0] rcat;
    logic [34:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_p[k]  = '0;
      assign root_p[k] = '0;
      assign x_p[k]    = x;
      assign sd_p[k]   = side_in;
    end else begin : g_next
      assign rem_p[k]  = rem_q[k-1];
      assign root_p[k] = root_q[k-1];
      assign x_p[k]    = x_q[k-1];
      assign sd_p[k]   = sd_q[k-1];
    end

    assign rcat  = {rem_p[k][32:0], x_p[k][63:62]};
    assign trial = {1'b0, root_p[k], 2'b01};
    assign ge    = (rcat >= trial);

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_q[k]  <= ge ? rcat - trial : rcat;
        root_q[k] <= {root_p[k][30:0], ge};
        x_q[k]    <= {x_p[k][61:0], 2'b00};
        sd_q[k]   <= sd_p[k];
      end
    end
  end

  assign root     = root_q[SQ_STAGES-1];
  assign side_out = sd_q[SQ_STAGES-1];

endmodule

>>> src/pbc_div.sv
// Pipelined restoring divider for an 8-bit quotient, one bit per stage, with sideband data.
// Depends on pbc_pkg.
module pbc_div #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              ce,
  input  logic [44:0]       n,
  input  logic [31:0]       b,
  input  logic [SIDE_W-1:0] side_in,
  output logic [7:0]        quo,
  output logic [SIDE_W-1:0] side_out
);
  import pbc_pkg::*;

  logic [44:0]       rem_q [DIV_STAGES];
  logic [7:0]        quo_q [DIV_STAGES];
  logic [SIDE_W-1:0] sd_q  [DIV_STAGES];

  logic [44:0]       rem_p [DIV_STAGES];
  logic [7:0]        quo_p [DIV_STAGES];
  logic [SIDE_W-1:0] sd_p  [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic [44:0] bs;
    logic        ge;

    if (j == 0) begin : g_first
      assign rem_p[j] = n;
      assign quo_p[j] = '0;
      assign sd_p[j]  = side_in;
    end else begin : g_next
      assign rem_p[j] = rem_q[j-1];
      assign quo_p[j] = quo_q[j-1];
      assign sd_p[j]  = sd_q[j-1];
    end

    assign bs = 45'({13'd0, b} << (DIV_STAGES - 1 - j));
    assign ge = (rem_p[j] >= bs);

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_q[j] <= ge ? rem_p[j] - bs : rem_p[j];
        quo_q[j] <= {quo_p[j][6:0], ge};
        sd_q[j]  <= sd_p[j];
      end
    end
  end

  assign quo      = quo_q[DIV_STAGES-1];
  assign side_out = sd_q[DIV_STAGES-1];

endmodule

>>> src/pbc_lane.sv
// One color channel of the curve pipeline: level lookup, discriminant, sqrt, divide, saturate.
// Depends on pbc_pkg, pbc_sqrt and pbc_div.
module pbc_lane #(
  parameter int LEVELS = pbc_pkg::LEVELS_DEF
) (
  input  logic              clk,
  input  logic              ce,
  input  pbc_pkg::pbc_cfg_t cfg,
  input  logic [7:0]        c_in,
  output logic [7:0]        c_out
);
  import pbc_pkg::*;

  localparam logic [MW-1:0] M    = MW'(LEVELS - 1);
  localparam ttab_t         TTAB = build_ttab(LEVELS - 1);

  // stage 1
  logic [MW-1:0]      t;
  logic [23:0]        s1_tm;
  logic signed [28:0] s1_ta;
  logic [7:0]         s1_c;
  // stage 2
  logic signed [40:0] s2_e;
  logic signed [28:0] s2_ta;
  logic [7:0]         s2_c;
  // stage 3
  logic signed [57:0] dsum;
  logic [63:0]        s3_x;
  logic signed [28:0] s3_ta;
  logic [7:0]         s3_c;
  // sqrt out
  logic [31:0]        s8;
  logic [36:0]        sq_side;
  logic signed [28:0] sq_ta;
  logic [7:0]         sq_c;
  // post
  logic signed [34:0] n8;
  logic signed [29:0] dif;
  logic [7:0]         p1_c;
  logic signed [43:0] num;
  logic [7:0]         p2_c;
  logic [44:0]        p3_n;
  logic               p3_zero;
  logic               p3_sat;
  logic [7:0]         p3_c;
  logic [31:0]        bden;
  logic [7:0]         quo;
  logic [9:0]         dv_side;

  assign t = TTAB[c_in];

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_tm <= t * M;
      s1_ta <= $signed({1'b0, t}) * cfg.a;
      s1_c  <= c_in;
      s2_e  <= cfg.a * $signed({1'b0, s1_tm});
      s2_ta <= s1_ta;
      s2_c  <= s1_c;
      s3_x  <= dsum[57] ? '0 : {1'b0, dsum[56:0], 6'd0};
      s3_ta <= s2_ta;
      s3_c  <= s2_c;
    end
  end

  assign dsum = $signed({2'b00, cfg.d1sq}) + $signed({s2_e[40], s2_e, 16'd0});

  pbc_sqrt #(.SIDE_W(37)) u_sqrt (
    .clk      (clk),
    .ce       (ce),
    .x        (s3_x),
    .side_in  ({s3_ta, s3_c}),
    .root     (s8),
    .side_out (sq_side)
  );

  assign sq_ta = $signed(sq_side[36:8]);
  assign sq_c  = sq_side[7:0];
  assign dif   = $signed({cfg.d1[28], cfg.d1}) - $signed({sq_ta[28], sq_ta});
  assign bden  = {cfg.den, 1'b0};

  always_ff @(posedge clk) begin
    if (ce) begin
      n8   <= 35'(($signed({{5{dif[29]}}, dif}) <<< 3) + $signed({3'b000, s8}));
      p1_c <= sq_c;
      num  <= cfg.neg ? 44'(-((44'(n8) <<< 8) - 44'(n8))) : 44'((44'(n8) <<< 8) - 44'(n8));
      p2_c <= p1_c;
      p3_zero <= (num <= 44'sd0);
      p3_n    <= 45'({num[43:0], 1'b0}) + 45'(cfg.den);
      p3_sat  <= (45'({num[43:0], 1'b0}) + 45'(cfg.den)) >= 45'({bden, 8'd0});
      p3_c    <= p2_c;
    end
  end

  pbc_div #(.SIDE_W(10)) u_div (
    .clk      (clk),
    .ce       (ce),
    .n        (p3_n),
    .b        (bden),
    .side_in  ({p3_zero, p3_sat, p3_c}),
    .quo      (quo),
    .side_out (dv_side)
  );

  always_ff @(posedge clk) begin
    if (ce) begin
      if (cfg.ident) begin
        c_out <= dv_side[7:0];
      end else if (dv_side[9]) begin
        c_out <= 8'd0;
      end else if (dv_side[8]) begin
        c_out <= 8'd255;
      end else begin
        c_out <= quo;
      end
    end
  end

endmodule
